// File: hdl/cpg_pkg.sv
// shared constants, types and trig tables for the circle point generator
// no dependencies; every other file refers to it by scoped names
package cpg_pkg;

  localparam int ANGLE_STEPS  = 360;
  localparam int RADIUS_BITS  = 10;
  localparam int COORD_BITS   = RADIUS_BITS + 1;
  localparam int KEY_W        = 2 * COORD_BITS;
  localparam int ANGLE_W      = $clog2(ANGLE_STEPS);
  localparam int COUNT_W      = $clog2(ANGLE_STEPS + 1);
  localparam int COLOR_W      = 8;

  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ID = CFG_INDEX_W'(1);

  // trig values are unsigned magnitudes with 16 fraction bits, 1.0 included
  localparam int Q16_W        = 17;
  localparam int Q16_FRAC     = 16;
  localparam int TAYLOR_TERMS = 12;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // 4*k mod steps only takes multiples of gcd(4, steps)
  localparam int GCD_SHIFT    = (ANGLE_STEPS % 4 == 0) ? 2 : ((ANGLE_STEPS % 2 == 0) ? 1 : 0);
  localparam int TRIG_ENTRIES = ANGLE_STEPS >> GCD_SHIFT;
  localparam int TRIG_IDX_W   = (TRIG_ENTRIES > 1) ? $clog2(TRIG_ENTRIES) : 1;

  typedef logic [TRIG_ENTRIES-1:0][Q16_W-1:0] trig_tab_t;

  // query word that walks down the cell row
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] left;    // stored points not yet passed
    logic               hit;
    logic               placed;
  } scan_tok_t;

  // taylor term divisor j*(j+1)
  function automatic logic [63:0] div_fact(input logic [63:0] v, input int j);
    logic [63:0] r;
    case (j)
      1:       r = v / 64'd2;
      2:       r = v / 64'd6;
      3:       r = v / 64'd12;
      4:       r = v / 64'd20;
      5:       r = v / 64'd30;
      6:       r = v / 64'd42;
      7:       r = v / 64'd56;
      8:       r = v / 64'd72;
      9:       r = v / 64'd90;
      10:      r = v / 64'd110;
      11:      r = v / 64'd132;
      12:      r = v / 64'd156;
      13:      r = v / 64'd182;
      14:      r = v / 64'd210;
      15:      r = v / 64'd240;
      16:      r = v / 64'd272;
      17:      r = v / 64'd306;
      18:      r = v / 64'd342;
      19:      r = v / 64'd380;
      20:      r = v / 64'd420;
      21:      r = v / 64'd462;
      22:      r = v / 64'd506;
      23:      r = v / 64'd552;
      24:      r = v / 64'd600;
      default: r = v;
    endcase
    return r;
  endfunction

  // series in q30 over the first quadrant, rounded to q16
  function automatic trig_tab_t build_trig(input bit odd);
    trig_tab_t   tab;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    longint      sum;
    int          n;
    int          j;
    tab = '0;
    for (int idx = 0; idx < TRIG_ENTRIES; idx++) begin
      a    = (HALF_PI_Q30 * 64'(idx << GCD_SHIFT)) / 64'(ANGLE_STEPS);
      a2   = (a * a) >> 30;
      term = odd ? a : (64'd1 << 30);
      sum  = longint'(term);
      for (n = 1; n <= TAYLOR_TERMS; n++) begin
        j    = 2 * n - 1 + (odd ? 1 : 0);
        term = div_fact((term * a2) >> 30, j);
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
        sum = longint'(1) << 30;
      end
      tab[idx] = Q16_W'((sum + 8192) >>> 14);
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig(1'b1);
  localparam trig_tab_t COS_TAB = build_trig(1'b0);

endpackage

// File: hdl/cpg_cell.sv
// one cell of the stored point row: holds one point, checks the passing query word
// and claims it when it is the first free cell; uses cpg_pkg
module cpg_cell (
  input  logic              clk,
  input  logic              rst,
  input  cpg_pkg::scan_tok_t tok_in,
  output cpg_pkg::scan_tok_t tok_out
);

  logic [cpg_pkg::KEY_W-1:0] entry;
  logic                      occupied;
  logic                      match;
  logic                      put;
  cpg_pkg::scan_tok_t        tok_next;

  always_comb begin
    occupied = (tok_in.left != '0);
    match    = tok_in.valid && occupied && (entry == tok_in.key);
    // first free cell takes the point unless it was already seen
    put      = tok_in.valid && !occupied && !tok_in.hit && !tok_in.placed;
    tok_next        = tok_in;
    tok_next.left   = occupied ? (tok_in.left - 1'b1) : '0;
    tok_next.hit    = tok_in.hit || match;
    tok_next.placed = tok_in.placed || put;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
    if (put) begin
      entry <= tok_in.key;
    end
  end

endmodule

// File: hdl/cpg_point_calc.sv
// angle to packed point pipeline: reduce, quadrant, table lookup, scale, sign
// four register stages; uses cpg_pkg tables and widths
module cpg_point_calc (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cpg_pkg::ANGLE_W-1:0]       angle_index,
  input  logic [cpg_pkg::RADIUS_BITS-1:0]   radius,
  output logic                              key_valid,
  output logic [cpg_pkg::KEY_W-1:0]         key
);

  localparam int M_W    = cpg_pkg::ANGLE_W + 2;
  localparam int PROD_W = cpg_pkg::Q16_W + cpg_pkg::RADIUS_BITS + 1;

  // stage 1 logic
  logic [cpg_pkg::ANGLE_W:0]   ang_ext;
  logic [cpg_pkg::ANGLE_W-1:0] k;
  logic [M_W-1:0]              m;
  logic [M_W-1:0]              base;
  logic [M_W-1:0]              rem;
  logic                        ge1;
  logic                        ge2;
  logic                        ge3;

  // stage registers
  logic                              v1;
  logic                              v2;
  logic                              v3;
  logic [1:0]                        quad1;
  logic [cpg_pkg::TRIG_IDX_W-1:0]    idx1;
  logic [cpg_pkg::Q16_W-1:0]         tx2;
  logic [cpg_pkg::Q16_W-1:0]         ty2;
  logic                              negx2;
  logic                              negy2;
  logic [cpg_pkg::RADIUS_BITS-1:0]   magx3;
  logic [cpg_pkg::RADIUS_BITS-1:0]   magy3;
  logic                              negx3;
  logic                              negy3;

  logic [cpg_pkg::Q16_W-1:0]         sin_v;
  logic [cpg_pkg::Q16_W-1:0]         cos_v;
  logic [PROD_W-1:0]                 prodx;
  logic [PROD_W-1:0]                 prody;
  logic [cpg_pkg::COORD_BITS-1:0]    magx_ext;
  logic [cpg_pkg::COORD_BITS-1:0]    magy_ext;
  logic [cpg_pkg::COORD_BITS-1:0]    cx;
  logic [cpg_pkg::COORD_BITS-1:0]    cy;

  always_comb begin
    ang_ext = {1'b0, angle_index};
    // wrap angles past the last step
    if (ang_ext >= (cpg_pkg::ANGLE_W + 1)'(cpg_pkg::ANGLE_STEPS)) begin
      k = cpg_pkg::ANGLE_W'(ang_ext - (cpg_pkg::ANGLE_W + 1)'(cpg_pkg::ANGLE_STEPS));
    end else begin
      k = angle_index;
    end
    m   = {k, 2'b00};
    ge1 = (m >= M_W'(cpg_pkg::ANGLE_STEPS));
    ge2 = (m >= M_W'(2 * cpg_pkg::ANGLE_STEPS));
    ge3 = (m >= M_W'(3 * cpg_pkg::ANGLE_STEPS));
    if (ge3) begin
      base = M_W'(3 * cpg_pkg::ANGLE_STEPS);
    end else if (ge2) begin
      base = M_W'(2 * cpg_pkg::ANGLE_STEPS);
    end else if (ge1) begin
      base = M_W'(cpg_pkg::ANGLE_STEPS);
    end else begin
      base = '0;
    end
    rem = m - base;
  end

  always_comb begin
    sin_v = cpg_pkg::SIN_TAB[idx1];
    cos_v = cpg_pkg::COS_TAB[idx1];
    prodx = PROD_W'(tx2) * PROD_W'(radius) + PROD_W'(1 << (cpg_pkg::Q16_FRAC - 1));
    prody = PROD_W'(ty2) * PROD_W'(radius) + PROD_W'(1 << (cpg_pkg::Q16_FRAC - 1));
    magx_ext = {1'b0, magx3};
    magy_ext = {1'b0, magy3};
    cx = negx3 ? (~magx_ext + 1'b1) : magx_ext;
    cy = negy3 ? (~magy_ext + 1'b1) : magy_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      key_valid <= 1'b0;
    end else begin
      v1        <= start;
      v2        <= v1;
      v3        <= v2;
      key_valid <= v3;
    end
    quad1 <= {ge2, (ge1 & ~ge2) | ge3};
    idx1  <= cpg_pkg::TRIG_IDX_W'(rem >> cpg_pkg::GCD_SHIFT);
    // odd quadrants swap sine and cosine
    tx2   <= quad1[0] ? sin_v : cos_v;
    ty2   <= quad1[0] ? cos_v : sin_v;
    negx2 <= quad1[0] ^ quad1[1];
    negy2 <= quad1[1];
    magx3 <= prodx[cpg_pkg::Q16_FRAC +: cpg_pkg::RADIUS_BITS];
    magy3 <= prody[cpg_pkg::Q16_FRAC +: cpg_pkg::RADIUS_BITS];
    negx3 <= negx2;
    negy3 <= negy2;
    key   <= {cx, cy};
  end

endmodule

// File: hdl/circle_point_generator_core.sv
// circle point generator top level: control, config registers, output register
// depends on cpg_pkg, cpg_point_calc and cpg_cell
//
// input channel angle_valid/angle_ready carries angle_index and new_shape.
// output channel point_valid/point_ready carries point_x, point_y (two's
// complement) and point_color; an angle yields one word or none.
// config channel cfg_valid/cfg_ready writes radius (index 0) or color_id
// (index 1); cfg_ready is always high, other indexes are dropped.
// each angle runs through reduction, table lookup and scaling,
// then its query word walks the row of ANGLE_STEPS cells one cell a cycle,
// checking stored points and claiming the first free cell. the next angle
// is taken only after the word has been loaded into the output register
// or dropped; angle_ready stays low while an angle is in flight.
// reset empties the point set and clears radius and color_id to zero.
// a stalled receiver holds the word in the output register; the next angle
// is still accepted and its result waits in a hold register until free.
module circle_point_generator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                angle_valid,
  output logic                                angle_ready,
  input  logic [cpg_pkg::ANGLE_W-1:0]         angle_index,
  input  logic                                new_shape,
  output logic                                point_valid,
  input  logic                                point_ready,
  output logic signed [cpg_pkg::COORD_BITS-1:0] point_x,
  output logic signed [cpg_pkg::COORD_BITS-1:0] point_y,
  output logic [cpg_pkg::COLOR_W-1:0]         point_color,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cpg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cpg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t                            state;
  logic [cpg_pkg::COUNT_W-1:0]       count;
  logic [cpg_pkg::RADIUS_BITS-1:0]   radius;
  logic [cpg_pkg::COLOR_W-1:0]       color_id;
  logic [cpg_pkg::KEY_W-1:0]         hold_key;

  logic                              accept;
  logic                              out_free;
  logic                              load_out;
  logic                              calc_valid;
  logic [cpg_pkg::KEY_W-1:0]         calc_key;
  cpg_pkg::scan_tok_t                link [0:cpg_pkg::ANGLE_STEPS];
  cpg_pkg::scan_tok_t                exit_tok;

  assign angle_ready = (state == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign accept      = angle_valid && angle_ready;
  assign out_free    = !point_valid || point_ready;
  assign load_out    = out_free &&
                       ((state == S_SCAN && exit_tok.valid && exit_tok.placed) ||
                        state == S_HOLD);

  cpg_point_calc u_calc (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .angle_index (angle_index),
    .radius      (radius),
    .key_valid   (calc_valid),
    .key         (calc_key)
  );

  always_comb begin
    link[0].valid  = calc_valid;
    link[0].key    = calc_key;
    link[0].left   = count;
    link[0].hit    = 1'b0;
    link[0].placed = 1'b0;
  end

  for (genvar i = 0; i < cpg_pkg::ANGLE_STEPS; i++) begin : g_cell
    cpg_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  assign exit_tok = link[cpg_pkg::ANGLE_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      radius      <= '0;
      color_id    <= '0;
      point_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cpg_pkg::REG_RADIUS:   radius   <= cfg_data[cpg_pkg::RADIUS_BITS-1:0];
          cpg_pkg::REG_COLOR_ID: color_id <= cfg_data[cpg_pkg::COLOR_W-1:0];
          default: ;
        endcase
      end
      if (point_valid && point_ready && !load_out) begin
        point_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (new_shape) begin
              count <= '0;
            end
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (calc_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (exit_tok.valid) begin
            hold_key <= exit_tok.key;
            if (exit_tok.placed) begin
              count <= count + 1'b1;
              if (out_free) begin
                point_valid <= 1'b1;
                point_x     <= exit_tok.key[cpg_pkg::COORD_BITS +: cpg_pkg::COORD_BITS];
                point_y     <= exit_tok.key[cpg_pkg::COORD_BITS-1:0];
                point_color <= color_id;
                state       <= S_IDLE;
              end else begin
                state <= S_HOLD;
              end
            end else begin
              // seen before, or no free cell left
              state <= S_IDLE;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            point_valid <= 1'b1;
            point_x     <= hold_key[cpg_pkg::COORD_BITS +: cpg_pkg::COORD_BITS];
            point_y     <= hold_key[cpg_pkg::COORD_BITS-1:0];
            point_color <= color_id;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_exit_in_scan: assert property (@(posedge clk) disable iff (rst)
    exit_tok.valid |-> state == S_SCAN)
    else $error("query word left the cell row outside the scan state");

  a_calc_in_calc: assert property (@(posedge clk) disable iff (rst)
    calc_valid |-> state == S_CALC)
    else $error("point calc finished outside the calc state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cpg_pkg::COUNT_W'(cpg_pkg::ANGLE_STEPS))
    else $error("stored point count past the row length");

  a_place_or_hit: assert property (@(posedge clk) disable iff (rst)
    exit_tok.valid |-> !(exit_tok.placed && exit_tok.hit))
    else $error("point both matched and stored");

  a_point_source: assert property (@(posedge clk) disable iff (rst)
    $rose(point_valid) |-> ($past(state) == S_SCAN || $past(state) == S_HOLD))
    else $error("output word loaded outside scan or hold");

endmodule
